[sv/js_numeric_literal_scanner_defines.svh]
// Assertion macros for the numeric literal scanner checker.
// No dependencies; included by files that hold assertions.
`ifndef JS_NUMERIC_LITERAL_SCANNER_DEFINES_SVH
`define JS_NUMERIC_LITERAL_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define JNLS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define JNLS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/jnls_pkg.sv]
// Package for the numeric literal scanner: beat types, scan phases, byte codes
// and byte class helpers. No dependencies.
package jnls_pkg;

  localparam int unsigned LENGTH_BITS = 16;

  typedef enum logic [1:0] {
    TOK_NONE    = 2'd0,
    TOK_NUMERIC = 2'd1,
    TOK_BIGINT  = 2'd2,
    TOK_INVALID = 2'd3
  } tok_kind_e;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_DOT_START  = 5'd1,
    PH_ZERO       = 5'd2,
    PH_INT        = 5'd3,
    PH_FRAC_FIRST = 5'd4,
    PH_FRAC       = 5'd5,
    PH_EXP_START  = 5'd6,
    PH_EXP_SIGN   = 5'd7,
    PH_EXP_DIGITS = 5'd8,
    PH_OCT_FIRST  = 5'd9,
    PH_OCT        = 5'd10,
    PH_BIN_FIRST  = 5'd11,
    PH_BIN        = 5'd12,
    PH_HEX_FIRST  = 5'd13,
    PH_HEX        = 5'd14,
    PH_LEGACY     = 5'd15
  } phase_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       begin_req;
    logic       at_end;
  } in_beat_t;

  typedef struct packed {
    tok_kind_e              token_kind;
    logic [LENGTH_BITS-1:0] literal_length;
  } out_beat_t;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_LO_O  = 8'h6F;
  localparam logic [7:0] CH_UP_O  = 8'h4F;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  function automatic logic is_dec(input logic [7:0] c);
    return c inside {[CH_0:CH_9]};
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[CH_0:CH_9], [CH_LO_A:CH_LO_F], [CH_UP_A:CH_UP_F]};
  endfunction

  // Digit class of the current radix.
  function automatic logic class_ok(input phase_e ph, input logic [7:0] c);
    logic ok;
    case (ph)
      PH_OCT_FIRST, PH_OCT: ok = c inside {[CH_0:CH_7]};
      PH_BIN_FIRST, PH_BIN: ok = (c == CH_0) || (c == CH_1);
      PH_HEX_FIRST, PH_HEX: ok = is_hex(c);
      default:              ok = is_dec(c);
    endcase
    return ok;
  endfunction

endpackage

[sv/js_numeric_literal_scanner.sv]
// Numeric literal scanner: results are registered. Throughput one byte per cycle
// while in_stall_o is low; a two-entry output (register plus skid)
// lets input continue while a result waits, in_stall_o rises only when both are full.
// rst_ni (async, low) clears scan phase, byte count, held separator and
// invalid flag, and empties the output register and skid entry.
module js_numeric_literal_scanner (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  jnls_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jnls_pkg::out_beat_t out_beat_o
);

  localparam int unsigned LB = jnls_pkg::LENGTH_BITS;

  jnls_pkg::phase_e    ph_q, ph_d;
  logic [LB-1:0]       cnt_q, cnt_d;
  logic                hold_q, hold_d;
  logic                bad_q, bad_d;

  logic                out_valid_q, skid_valid_q;
  jnls_pkg::out_beat_t out_q, skid_q;

  logic                acc, out_take;
  logic                res_valid;
  jnls_pkg::out_beat_t res;

  assign in_stall_o  = skid_valid_q;
  assign acc         = in_valid_i && !skid_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  always_comb begin
    logic [7:0]          c;
    logic [LB-1:0]       cnt_base;
    logic [1:0]          add;
    logic [LB:0]         sum;
    logic                emit;
    jnls_pkg::tok_kind_e kind;
    logic                use_loop, allow_n, allow_exp;

    c         = in_beat_i.at_end ? 8'h00 : in_beat_i.byte_value;
    ph_d      = ph_q;
    hold_d    = hold_q;
    bad_d     = bad_q;
    cnt_base  = cnt_q;
    add       = 2'd0;
    emit      = 1'b0;
    kind      = jnls_pkg::TOK_NONE;
    use_loop  = 1'b0;
    allow_n   = 1'b0;
    allow_exp = 1'b0;

    if (in_beat_i.begin_req) begin
      cnt_base = '0;
      hold_d   = 1'b0;
      bad_d    = 1'b0;
      if (c == jnls_pkg::CH_0) begin
        add  = 2'd1;
        ph_d = jnls_pkg::PH_ZERO;
      end else if (jnls_pkg::is_dec(c)) begin
        add  = 2'd1;
        ph_d = jnls_pkg::PH_INT;
      end else if (c == jnls_pkg::CH_DOT) begin
        ph_d = jnls_pkg::PH_DOT_START;
      end else begin
        emit = 1'b1;
      end
    end else if (ph_q == jnls_pkg::PH_IDLE) begin
      ph_d = jnls_pkg::PH_IDLE;
    end else if (hold_q) begin
      hold_d = 1'b0;
      if (jnls_pkg::class_ok(ph_q, c)) begin
        add = 2'd2;
      end else begin
        emit = 1'b1;
        kind = jnls_pkg::TOK_NUMERIC;
      end
    end else begin
      case (ph_q)
        jnls_pkg::PH_DOT_START: begin
          if (jnls_pkg::is_dec(c)) begin
            add  = 2'd2;
            ph_d = jnls_pkg::PH_FRAC;
          end else begin
            emit = 1'b1;
          end
        end
        jnls_pkg::PH_ZERO: begin
          add = 2'd1;
          if (c == jnls_pkg::CH_DOT) begin
            ph_d = jnls_pkg::PH_FRAC_FIRST;
          end else if (c == jnls_pkg::CH_LO_E || c == jnls_pkg::CH_UP_E) begin
            ph_d = jnls_pkg::PH_EXP_START;
          end else if (c == jnls_pkg::CH_LO_O || c == jnls_pkg::CH_UP_O) begin
            ph_d = jnls_pkg::PH_OCT_FIRST;
          end else if (c == jnls_pkg::CH_LO_B || c == jnls_pkg::CH_UP_B) begin
            ph_d = jnls_pkg::PH_BIN_FIRST;
          end else if (c == jnls_pkg::CH_LO_X || c == jnls_pkg::CH_UP_X) begin
            ph_d = jnls_pkg::PH_HEX_FIRST;
          end else if (c == jnls_pkg::CH_N) begin
            emit = 1'b1;
            kind = jnls_pkg::TOK_BIGINT;
          end else if (jnls_pkg::is_dec(c)) begin
            ph_d = jnls_pkg::PH_LEGACY;
          end else begin
            add  = 2'd0;
            emit = 1'b1;
            kind = jnls_pkg::TOK_NUMERIC;
          end
        end
        jnls_pkg::PH_INT: begin
          if (c == jnls_pkg::CH_DOT) begin
            add  = 2'd1;
            ph_d = jnls_pkg::PH_FRAC_FIRST;
          end else begin
            use_loop  = 1'b1;
            allow_n   = 1'b1;
            allow_exp = 1'b1;
          end
        end
        jnls_pkg::PH_FRAC_FIRST: begin
          ph_d      = jnls_pkg::PH_FRAC;
          use_loop  = 1'b1;
          allow_exp = 1'b1;
          if (c == jnls_pkg::CH_US) bad_d = 1'b1;
        end
        jnls_pkg::PH_FRAC: begin
          use_loop  = 1'b1;
          allow_exp = 1'b1;
        end
        jnls_pkg::PH_EXP_START, jnls_pkg::PH_EXP_SIGN: begin
          if (ph_q == jnls_pkg::PH_EXP_START &&
              (c == jnls_pkg::CH_PLUS || c == jnls_pkg::CH_MINUS)) begin
            add  = 2'd1;
            ph_d = jnls_pkg::PH_EXP_SIGN;
          end else if (jnls_pkg::is_dec(c)) begin
            add  = 2'd1;
            ph_d = jnls_pkg::PH_EXP_DIGITS;
          end else begin
            bad_d = 1'b1;
            emit  = 1'b1;
            kind  = jnls_pkg::TOK_NUMERIC;
          end
        end
        jnls_pkg::PH_EXP_DIGITS: begin
          use_loop = 1'b1;
        end
        jnls_pkg::PH_OCT_FIRST, jnls_pkg::PH_BIN_FIRST, jnls_pkg::PH_HEX_FIRST: begin
          if (jnls_pkg::class_ok(ph_q, c)) begin
            add = 2'd1;
            case (ph_q)
              jnls_pkg::PH_OCT_FIRST: ph_d = jnls_pkg::PH_OCT;
              jnls_pkg::PH_BIN_FIRST: ph_d = jnls_pkg::PH_BIN;
              default:                ph_d = jnls_pkg::PH_HEX;
            endcase
          end else begin
            bad_d = 1'b1;
            emit  = 1'b1;
            if (c == jnls_pkg::CH_N) begin
              add  = 2'd1;
              kind = jnls_pkg::TOK_BIGINT;
            end else begin
              kind = jnls_pkg::TOK_NUMERIC;
            end
          end
        end
        jnls_pkg::PH_OCT, jnls_pkg::PH_BIN, jnls_pkg::PH_HEX: begin
          use_loop = 1'b1;
          allow_n  = 1'b1;
        end
        jnls_pkg::PH_LEGACY: begin
          if (jnls_pkg::is_dec(c)) begin
            add = 2'd1;
          end else begin
            emit = 1'b1;
            kind = jnls_pkg::TOK_NUMERIC;
          end
        end
        default: begin
          ph_d     = jnls_pkg::PH_IDLE;
          cnt_base = '0;
          hold_d   = 1'b0;
          bad_d    = 1'b0;
        end
      endcase

      // shared digit loop; class_ok sees frac-first as decimal
      if (use_loop) begin
        if (jnls_pkg::class_ok(ph_q, c)) begin
          add = 2'd1;
        end else if (c == jnls_pkg::CH_US) begin
          hold_d = 1'b1;
        end else if (allow_n && c == jnls_pkg::CH_N) begin
          add  = 2'd1;
          emit = 1'b1;
          kind = jnls_pkg::TOK_BIGINT;
        end else if (allow_exp && (c == jnls_pkg::CH_LO_E || c == jnls_pkg::CH_UP_E)) begin
          add  = 2'd1;
          ph_d = jnls_pkg::PH_EXP_START;
        end else begin
          emit = 1'b1;
          kind = jnls_pkg::TOK_NUMERIC;
        end
      end
    end

    sum   = {1'b0, cnt_base} + {{(LB-1){1'b0}}, add};
    cnt_d = sum[LB] ? '1 : sum[LB-1:0];

    res_valid = emit;
    res.token_kind     = (kind != jnls_pkg::TOK_NONE && bad_d) ? jnls_pkg::TOK_INVALID : kind;
    res.literal_length = (kind == jnls_pkg::TOK_NONE) ? '0 : cnt_d;

    if (emit) begin
      ph_d   = jnls_pkg::PH_IDLE;
      cnt_d  = '0;
      hold_d = 1'b0;
      bad_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= jnls_pkg::PH_IDLE;
      cnt_q  <= '0;
      hold_q <= 1'b0;
      bad_q  <= 1'b0;
    end else if (acc) begin
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
      hold_q <= hold_d;
      bad_q  <= bad_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) skid_valid_q <= 1'b0;
    end else if (acc) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= res_valid;
      end else if (res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) out_q <= skid_q;
    end else if (acc) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else if (res_valid) begin
        skid_q <= res;
      end
    end
  end

endmodule

[sv/jnls_checker.sv]
// Port-level checker for the numeric literal scanner, bound to the top level.
// Depends on jnls_pkg and js_numeric_literal_scanner_defines.svh.
`include "js_numeric_literal_scanner_defines.svh"

module jnls_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input jnls_pkg::out_beat_t out_beat_o
);

  `JNLS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_beat_o), "stalled result beat changed")
  `JNLS_ASSERT_NOW(a_none_zero_len, clk_i, rst_ni, out_valid_o && out_beat_o.token_kind == jnls_pkg::TOK_NONE, out_beat_o.literal_length == '0, "non-literal beat with nonzero length")
  `JNLS_ASSERT_NOW(a_lit_has_len, clk_i, rst_ni, out_valid_o && out_beat_o.token_kind != jnls_pkg::TOK_NONE, out_beat_o.literal_length != '0, "literal beat with zero length")
  `JNLS_ASSERT_NOW(a_stall_needs_out, clk_i, rst_ni, !out_valid_o, !in_stall_o, "input stalled with empty output")

endmodule

bind js_numeric_literal_scanner jnls_checker u_jnls_checker (.*);

[verif/testbench.sv]
// Self-checking bench for js_numeric_literal_scanner: streams source bytes over the
// valid/stall input channel and scores every token beat against an in-bench scanner.
// Depends on jnls_pkg and the scanner RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 20_000;
  localparam int unsigned DRAIN_LIMIT = 1_000;
  localparam logic [jnls_pkg::LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam logic [7:0] CH_SPACE = 8'h20;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  jnls_pkg::in_beat_t  in_beat   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  jnls_pkg::out_beat_t out_beat;

  // scanner model state
  jnls_pkg::phase_e                 scan_ph  = jnls_pkg::PH_IDLE;
  logic [jnls_pkg::LENGTH_BITS-1:0] run_len  = '0;
  bit                               sep_held = 1'b0;
  bit                               lit_bad  = 1'b0;

  jnls_pkg::out_beat_t pending_tokens[$];
  logic [7:0]          lit_bytes[$];
  int unsigned         mismatches    = 0;
  int unsigned         live_bytes    = 0;
  int unsigned         cycles        = 0;
  int                  in_idle_pct   = 0;
  int                  out_stall_pct = 0;

  js_numeric_literal_scanner u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_scan();
    scan_ph  = jnls_pkg::PH_IDLE;
    run_len  = '0;
    sep_held = 1'b0;
    lit_bad  = 1'b0;
  endfunction

  function automatic void bump_len(int unsigned n);
    longint unsigned sum;
    sum = run_len + n;
    run_len = (sum > LEN_MAX) ? LEN_MAX : sum[jnls_pkg::LENGTH_BITS-1:0];
  endfunction

  function automatic bit is_digit10(logic [7:0] c);
    return c >= jnls_pkg::CH_0 && c <= jnls_pkg::CH_9;
  endfunction

  function automatic bit fits_radix(jnls_pkg::phase_e ph, logic [7:0] c);
    case (ph)
      jnls_pkg::PH_OCT_FIRST, jnls_pkg::PH_OCT:
        return c >= jnls_pkg::CH_0 && c <= jnls_pkg::CH_7;
      jnls_pkg::PH_BIN_FIRST, jnls_pkg::PH_BIN:
        return c == jnls_pkg::CH_0 || c == jnls_pkg::CH_1;
      jnls_pkg::PH_HEX_FIRST, jnls_pkg::PH_HEX:
        return is_digit10(c) || (c >= jnls_pkg::CH_LO_A && c <= jnls_pkg::CH_LO_F) ||
               (c >= jnls_pkg::CH_UP_A && c <= jnls_pkg::CH_UP_F);
      default:
        return is_digit10(c);
    endcase
  endfunction

  function automatic void digit_run(input logic [7:0] c, input bit allow_n,
                                    input bit allow_exp, inout bit done,
                                    inout jnls_pkg::tok_kind_e kind);
    if (fits_radix(scan_ph, c)) begin
      bump_len(1);
    end else if (c == jnls_pkg::CH_US) begin
      sep_held = 1'b1;
    end else if (allow_n && c == jnls_pkg::CH_N) begin
      bump_len(1);
      done = 1'b1;
      kind = jnls_pkg::TOK_BIGINT;
    end else if (allow_exp && (c == jnls_pkg::CH_LO_E || c == jnls_pkg::CH_UP_E)) begin
      bump_len(1);
      scan_ph = jnls_pkg::PH_EXP_START;
    end else begin
      done = 1'b1;
    end
  endfunction

  // Advances the model by one accepted beat; returns 1 when a token is due.
  function automatic bit scan_next_byte(input jnls_pkg::in_beat_t b,
                                        output jnls_pkg::out_beat_t tok);
    logic [7:0]          c;
    bit                  done;
    jnls_pkg::tok_kind_e kind;
    c    = b.at_end ? 8'h00 : b.byte_value;
    done = 1'b0;
    kind = jnls_pkg::TOK_NUMERIC;
    tok  = '0;
    if (b.begin_req) begin
      clear_scan();
      if (c == jnls_pkg::CH_0) begin
        bump_len(1);
        scan_ph = jnls_pkg::PH_ZERO;
      end else if (is_digit10(c)) begin
        bump_len(1);
        scan_ph = jnls_pkg::PH_INT;
      end else if (c == jnls_pkg::CH_DOT) begin
        scan_ph = jnls_pkg::PH_DOT_START;
      end else begin
        done = 1'b1;
        kind = jnls_pkg::TOK_NONE;
      end
    end else if (scan_ph == jnls_pkg::PH_IDLE) begin
      // stray byte, dropped
    end else if (sep_held) begin
      sep_held = 1'b0;
      if (fits_radix(scan_ph, c)) bump_len(2);
      else done = 1'b1;
    end else begin
      case (scan_ph)
        jnls_pkg::PH_DOT_START: begin
          if (is_digit10(c)) begin
            bump_len(2);
            scan_ph = jnls_pkg::PH_FRAC;
          end else begin
            done = 1'b1;
            kind = jnls_pkg::TOK_NONE;
          end
        end
        jnls_pkg::PH_ZERO: begin
          if (c == jnls_pkg::CH_DOT) begin
            bump_len(1);
            scan_ph = jnls_pkg::PH_FRAC_FIRST;
          end else if (c == jnls_pkg::CH_LO_E || c == jnls_pkg::CH_UP_E) begin
            bump_len(1);
            scan_ph = jnls_pkg::PH_EXP_START;
          end else if (c == jnls_pkg::CH_LO_O || c == jnls_pkg::CH_UP_O) begin
            bump_len(1);
            scan_ph = jnls_pkg::PH_OCT_FIRST;
          end else if (c == jnls_pkg::CH_LO_B || c == jnls_pkg::CH_UP_B) begin
            bump_len(1);
            scan_ph = jnls_pkg::PH_BIN_FIRST;
          end else if (c == jnls_pkg::CH_LO_X || c == jnls_pkg::CH_UP_X) begin
            bump_len(1);
            scan_ph = jnls_pkg::PH_HEX_FIRST;
          end else if (c == jnls_pkg::CH_N) begin
            bump_len(1);
            done = 1'b1;
            kind = jnls_pkg::TOK_BIGINT;
          end else if (is_digit10(c)) begin
            bump_len(1);
            scan_ph = jnls_pkg::PH_LEGACY;
          end else begin
            done = 1'b1;
          end
        end
        jnls_pkg::PH_INT: begin
          if (c == jnls_pkg::CH_DOT) begin
            bump_len(1);
            scan_ph = jnls_pkg::PH_FRAC_FIRST;
          end else begin
            digit_run(c, 1'b1, 1'b1, done, kind);
          end
        end
        jnls_pkg::PH_FRAC_FIRST: begin
          scan_ph = jnls_pkg::PH_FRAC;
          if (c == jnls_pkg::CH_US) lit_bad = 1'b1;
          digit_run(c, 1'b0, 1'b1, done, kind);
        end
        jnls_pkg::PH_FRAC: digit_run(c, 1'b0, 1'b1, done, kind);
        jnls_pkg::PH_EXP_START, jnls_pkg::PH_EXP_SIGN: begin
          if (scan_ph == jnls_pkg::PH_EXP_START &&
              (c == jnls_pkg::CH_PLUS || c == jnls_pkg::CH_MINUS)) begin
            bump_len(1);
            scan_ph = jnls_pkg::PH_EXP_SIGN;
          end else if (is_digit10(c)) begin
            bump_len(1);
            scan_ph = jnls_pkg::PH_EXP_DIGITS;
          end else begin
            lit_bad = 1'b1;
            done    = 1'b1;
          end
        end
        jnls_pkg::PH_EXP_DIGITS: digit_run(c, 1'b0, 1'b0, done, kind);
        jnls_pkg::PH_OCT_FIRST, jnls_pkg::PH_BIN_FIRST, jnls_pkg::PH_HEX_FIRST: begin
          if (fits_radix(scan_ph, c)) begin
            bump_len(1);
            if (scan_ph == jnls_pkg::PH_OCT_FIRST) scan_ph = jnls_pkg::PH_OCT;
            else if (scan_ph == jnls_pkg::PH_BIN_FIRST) scan_ph = jnls_pkg::PH_BIN;
            else scan_ph = jnls_pkg::PH_HEX;
          end else begin
            lit_bad = 1'b1;
            done    = 1'b1;
            if (c == jnls_pkg::CH_N) begin
              bump_len(1);
              kind = jnls_pkg::TOK_BIGINT;
            end
          end
        end
        jnls_pkg::PH_OCT, jnls_pkg::PH_BIN, jnls_pkg::PH_HEX:
          digit_run(c, 1'b1, 1'b0, done, kind);
        jnls_pkg::PH_LEGACY: begin
          if (is_digit10(c)) bump_len(1);
          else done = 1'b1;
        end
        default: clear_scan();
      endcase
    end
    if (done) begin
      if (kind != jnls_pkg::TOK_NONE && lit_bad) kind = jnls_pkg::TOK_INVALID;
      tok.token_kind     = kind;
      tok.literal_length = (kind == jnls_pkg::TOK_NONE) ? '0 : run_len;
      clear_scan();
    end
    return done;
  endfunction

  task automatic push_byte(logic [7:0] v, bit start, bit eoi);
    jnls_pkg::in_beat_t  b;
    jnls_pkg::out_beat_t tok;
    b = '{byte_value: v, begin_req: start, at_end: eoi};
    if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (start || scan_ph != jnls_pkg::PH_IDLE) live_bytes++;
    if (scan_next_byte(b, tok)) pending_tokens.push_back(tok);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == 0, 1'b0);
  endtask

  task automatic add_digits(int radix, int count, bit seps);
    int d;
    for (int i = 0; i < count; i++) begin
      if (seps && i > 0 && $urandom_range(3) == 0) lit_bytes.push_back(jnls_pkg::CH_US);
      d = $urandom_range(radix - 1);
      if (d < 10) lit_bytes.push_back(8'(jnls_pkg::CH_0 + d));
      else if ($urandom_range(1)) lit_bytes.push_back(8'(jnls_pkg::CH_LO_A + d - 10));
      else lit_bytes.push_back(8'(jnls_pkg::CH_UP_A + d - 10));
    end
  endtask

  task automatic test_directed_cases();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    push_byte(8'hFF, 1'b0, 1'b0);   // stray byte while idle
    send_text("1_2n");
    send_text("0x");
    push_byte(8'hA5, 1'b0, 1'b1);   // bare prefix cut by end of input
    send_text("0bn");
    send_text("1e;");
    send_text("0._1");
    push_byte(8'hFF, 1'b0, 1'b0);
    send_text(".x");
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b1);
    send_text("07");
    send_text("5");                 // restart drops the legacy scan
    push_byte(8'h00, 1'b0, 1'b1);
    send_text("08_");
  endtask

  task automatic test_random_literals(int in_pct, int out_pct, int unsigned n_items);
    int unsigned stop_at;
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    stop_at = live_bytes + n_items;
    while (live_bytes < stop_at) begin
      lit_bytes.delete();
      case ($urandom_range(10))
        0: begin
          lit_bytes.push_back(8'(jnls_pkg::CH_1 + $urandom_range(8)));
          add_digits(10, $urandom_range(4), 1'b1);
          if ($urandom_range(2) == 0) lit_bytes.push_back(jnls_pkg::CH_N);
        end
        1: begin
          add_digits(10, $urandom_range(1, 3), 1'b1);
          lit_bytes.push_back(jnls_pkg::CH_DOT);
          if ($urandom_range(5) == 0) lit_bytes.push_back(jnls_pkg::CH_US);
          add_digits(10, $urandom_range(4), 1'b1);
        end
        2: begin
          add_digits(10, $urandom_range(1, 3), 1'b1);
          if ($urandom_range(1)) begin
            lit_bytes.push_back(jnls_pkg::CH_DOT);
            add_digits(10, $urandom_range(3), 1'b1);
          end
          lit_bytes.push_back($urandom_range(1) ? jnls_pkg::CH_LO_E : jnls_pkg::CH_UP_E);
          case ($urandom_range(2))
            0:       lit_bytes.push_back(jnls_pkg::CH_PLUS);
            1:       lit_bytes.push_back(jnls_pkg::CH_MINUS);
            default: ;
          endcase
          add_digits(10, $urandom_range(3), 1'b1);
        end
        3: begin
          lit_bytes.push_back(jnls_pkg::CH_DOT);
          add_digits(10, $urandom_range(3), 1'b1);
          if ($urandom_range(2) == 0) begin
            lit_bytes.push_back(jnls_pkg::CH_LO_E);
            add_digits(10, $urandom_range(2), 1'b1);
          end
        end
        4: begin
          lit_bytes.push_back(jnls_pkg::CH_0);
          lit_bytes.push_back($urandom_range(1) ? jnls_pkg::CH_LO_X : jnls_pkg::CH_UP_X);
          add_digits(16, $urandom_range(4), 1'b1);
          if ($urandom_range(2) == 0) lit_bytes.push_back(jnls_pkg::CH_N);
        end
        5: begin
          lit_bytes.push_back(jnls_pkg::CH_0);
          lit_bytes.push_back($urandom_range(1) ? jnls_pkg::CH_LO_O : jnls_pkg::CH_UP_O);
          add_digits(8, $urandom_range(4), 1'b1);
          if ($urandom_range(2) == 0) lit_bytes.push_back(jnls_pkg::CH_N);
        end
        6: begin
          lit_bytes.push_back(jnls_pkg::CH_0);
          lit_bytes.push_back($urandom_range(1) ? jnls_pkg::CH_LO_B : jnls_pkg::CH_UP_B);
          add_digits(2, $urandom_range(5), 1'b1);
          if ($urandom_range(2) == 0) lit_bytes.push_back(jnls_pkg::CH_N);
        end
        7: begin
          lit_bytes.push_back(jnls_pkg::CH_0);
          add_digits(10, $urandom_range(1, 4), 1'b0);
        end
        8: begin
          lit_bytes.push_back(jnls_pkg::CH_0);
          case ($urandom_range(3))
            0: begin
              lit_bytes.push_back(jnls_pkg::CH_DOT);
              add_digits(10, $urandom_range(3), 1'b1);
            end
            1: lit_bytes.push_back(jnls_pkg::CH_N);
            2: begin
              lit_bytes.push_back(jnls_pkg::CH_UP_E);
              add_digits(10, $urandom_range(2), 1'b1);
            end
            default: ;
          endcase
        end
        default: begin
          repeat ($urandom_range(1, 4)) lit_bytes.push_back(8'($urandom_range(255)));
        end
      endcase
      if ($urandom_range(7) == 0)
        lit_bytes[$urandom_range(lit_bytes.size() - 1)] = 8'($urandom_range(255));
      if ($urandom_range(9) == 0)
        lit_bytes.insert($urandom_range(lit_bytes.size()), jnls_pkg::CH_US);
      foreach (lit_bytes[i])
        push_byte(lit_bytes[i], i == 0, i == 0 && $urandom_range(19) == 0);
      case ($urandom_range(3))
        0:       push_byte(8'($urandom_range(255)), 1'b0, 1'b1);
        1:       push_byte(8'($urandom_range(255)), 1'b0, 1'b0);
        2:       push_byte(CH_SPACE, 1'b0, 1'b0);
        default: ;  // next literal restarts the scan
      endcase
    end
  endtask

  always @(posedge clk) begin : token_check
    jnls_pkg::out_beat_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_tokens.size() == 0) begin
          $error("unexpected token beat: token_kind %0d literal_length %0d",
                 out_beat.token_kind, out_beat.literal_length);
          mismatches++;
        end else begin
          want = pending_tokens.pop_front();
          if (out_beat.token_kind !== want.token_kind) begin
            $error("token_kind: expected %0d, actual %0d", want.token_kind,
                   out_beat.token_kind);
            mismatches++;
          end
          if (out_beat.literal_length !== want.literal_length) begin
            $error("literal_length: expected %0d, actual %0d", want.literal_length,
                   out_beat.literal_length);
            mismatches++;
          end
        end
      end
      out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : run
    int unsigned waited;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_literals(0, 0, 225);
    test_random_literals(48, 0, 225);
    test_random_literals(0, 48, 225);
    test_random_literals(22, 22, 225);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_tokens.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_tokens.size() != 0) begin
      $error("%0d expected token beats never arrived", pending_tokens.size());
      mismatches++;
    end
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
